[src/riscv_fast_form_rewriter_assert.svh]
// ----------------------------------------------------------------------------
// riscv_fast_form_rewriter_assert.svh - assertion macros
// Shared property macros for the fast-form rewriter checks.
// ----------------------------------------------------------------------------
`ifndef RISCV_FAST_FORM_REWRITER_ASSERT_SVH
`define RISCV_FAST_FORM_REWRITER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define RVFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rvfr check failed");

// next-cycle implication, disabled while in reset
`define RVFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rvfr check failed");

`endif

[src/rvfr_pkg.sv]
// ----------------------------------------------------------------------------
// rvfr_pkg - fast-form rewriter package
// Payload types, handler codes, opcodes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package rvfr_pkg;

	localparam int DEFAULT_ADDR_WIDTH = 64;

	// JAL targets must fit 32 bits after the alignment shift
	localparam int JAL_LIMIT_BASE = 32;

	localparam logic [4:0] REG_RA = 5'd1;

	localparam logic [6:0] OPC_OP     = 7'h33;
	localparam logic [6:0] OPC_OP_IMM = 7'h13;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_JAL    = 7'h6f;

	// compressed quadrant/funct3 match
	localparam logic [15:0] CI_OP_MASK   = 16'he003;
	localparam logic [15:0] CI_ADDI_CODE = 16'h0001;
	localparam logic [15:0] CI_LI_CODE   = 16'h4001;

	localparam logic [2:0] F3_B_EQ  = 3'd0;
	localparam logic [2:0] F3_B_NE  = 3'd1;
	localparam logic [2:0] F3_B_LT  = 3'd4;
	localparam logic [2:0] F3_B_GE  = 3'd5;
	localparam logic [2:0] F3_B_LTU = 3'd6;
	localparam logic [2:0] F3_B_GEU = 3'd7;
	localparam logic [2:0] F3_S_B   = 3'd0;
	localparam logic [2:0] F3_S_H   = 3'd1;
	localparam logic [2:0] F3_S_W   = 3'd2;
	localparam logic [2:0] F3_S_D   = 3'd3;

	typedef enum logic [4:0] {
		HC_NONE    = 5'd0,
		HC_ADD     = 5'd1,
		HC_LI      = 5'd2,
		HC_MV      = 5'd3,
		HC_ADDI    = 5'd4,
		HC_BEQZ    = 5'd5,
		HC_BNEZ    = 5'd6,
		HC_BLTZ    = 5'd7,
		HC_BGEZ    = 5'd8,
		HC_BEQ     = 5'd9,
		HC_BNE     = 5'd10,
		HC_BLT     = 5'd11,
		HC_BGE     = 5'd12,
		HC_BLTU    = 5'd13,
		HC_BGEU    = 5'd14,
		HC_SB_ZERO = 5'd15,
		HC_SH_ZERO = 5'd16,
		HC_SW_ZERO = 5'd17,
		HC_SD_ZERO = 5'd18,
		HC_SW_IMM  = 5'd19,
		HC_SD_IMM  = 5'd20,
		HC_JAL_X0  = 5'd21,
		HC_JAL_RA  = 5'd22,
		HC_C_ADDI  = 5'd23,
		HC_C_LI    = 5'd24
	} rvfr_code_t;

	typedef enum logic [2:0] {
		CFG_COMPRESSED_MODE = 3'd0,
		CFG_WIDE_XLEN       = 3'd1,
		CFG_INBOUND_ONLY    = 3'd2,
		CFG_EXEC_START      = 3'd3,
		CFG_EXEC_END        = 3'd4
	} rvfr_cfg_idx_t;

	typedef struct packed {
		logic        compressed_mode;
		logic        wide_xlen;
		logic        inbound_only;
	} rvfr_mode_t;

	typedef struct packed {
		logic [31:0] instr_word;
		logic [63:0] pc;
	} rvfr_in_t;

	typedef struct packed {
		logic [4:0]  handler_code;
		logic [31:0] fast_word;
	} rvfr_out_t;

endpackage

`default_nettype wire

[src/riscv_fast_form_rewriter.sv]
// ----------------------------------------------------------------------------
// riscv_fast_form_rewriter - RISC-V fast-form pre-decoder
// Rewrites fetched instruction words into compact handler words.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transfer per fetched word (instr_word plus its pc).
//   out_* : one transfer per input word: handler_code (0 = not rewritten)
//           and fast_word (compact form, or the input word unchanged).
//   cfg_* : register writes, index 0..4; cfg_ready is always high.
//           Only write while no item is in flight.
// Path: the input register captures the word, then the result register
//   captures its decoded form after one pass of decode logic and drives out_valid.
// Throughput: one item per cycle while the output is not stalled; the input
//   register accepts a new word in the same cycle its previous word moves into
//   the result register.
// Stall: while out_ready is low and the result register is full, the input
//   register holds and in_ready drops once it is full too. No item is lost.
// Reset: arst_n clears both valid flags and loads register defaults
//   (compressed_mode = 1, all others 0).
// ----------------------------------------------------------------------------
`default_nettype none

module riscv_fast_form_rewriter #(
	parameter int ADDR_WIDTH = rvfr_pkg::DEFAULT_ADDR_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rvfr_pkg::rvfr_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output rvfr_pkg::rvfr_out_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [63:0]         cfg_data
);
	import rvfr_pkg::*;

	// configuration registers
	rvfr_mode_t            mode_q;
	logic [ADDR_WIDTH-1:0] exec_start_q;
	logic [ADDR_WIDTH-1:0] exec_end_q;

	// stage 1: input register
	logic     valid_s1;
	rvfr_in_t item_s1;
	logic     adv_s1;

	// stage 2: result register
	logic      valid_q;
	rvfr_out_t res_q;
	rvfr_out_t res_d;

	assign cfg_ready = 1'b1;

	// bounds are kept at the address width, so compares need no masking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q.compressed_mode <= 1'b1;
			mode_q.wide_xlen       <= 1'b0;
			mode_q.inbound_only    <= 1'b0;
			exec_start_q           <= '0;
			exec_end_q             <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_COMPRESSED_MODE: mode_q.compressed_mode <= cfg_data[0];
				CFG_WIDE_XLEN:       mode_q.wide_xlen       <= cfg_data[0];
				CFG_INBOUND_ONLY:    mode_q.inbound_only    <= cfg_data[0];
				CFG_EXEC_START:      exec_start_q <= cfg_data[ADDR_WIDTH-1:0];
				CFG_EXEC_END:        exec_end_q   <= cfg_data[ADDR_WIDTH-1:0];
				default: begin
				end
			endcase
		end
	end

	// handshake: stage 1 moves on whenever the result register is free
	// or being drained this cycle
	assign adv_s1   = !valid_q || out_ready;
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	rvfr_decode #(
		.ADDR_WIDTH(ADDR_WIDTH)
	) u_decode (
		.item      (item_s1),
		.mode      (mode_q),
		.exec_start(exec_start_q),
		.exec_end  (exec_end_q),
		.result    (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv_s1) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			res_q <= res_d;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = res_q;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
`include "riscv_fast_form_rewriter_assert.svh"

	`RVFR_ASSERT_NEXT(a_in_lands_s1, clk, arst_n, in_valid && in_ready, valid_s1)
	`RVFR_ASSERT_NEXT(a_s1_lands_out, clk, arst_n, valid_s1 && adv_s1, out_valid)
	`RVFR_ASSERT_NOW(a_code_range, clk, arst_n, out_valid, out_data.handler_code <= HC_C_LI)
	`RVFR_ASSERT_NOW(a_c_form_rd, clk, arst_n,
		out_valid && (out_data.handler_code == HC_C_ADDI || out_data.handler_code == HC_C_LI),
		out_data.fast_word[4:0] != 5'd0 && out_data.fast_word[7:5] == 3'd0)

endmodule

`default_nettype wire

[src/rvfr_decode.sv]
// ----------------------------------------------------------------------------
// rvfr_decode - fast-form decode logic
// Combinational classification and repacking of one instruction word.
// ----------------------------------------------------------------------------
`default_nettype none

module rvfr_decode #(
	parameter int ADDR_WIDTH = rvfr_pkg::DEFAULT_ADDR_WIDTH
) (
	input  rvfr_pkg::rvfr_in_t   item,
	input  rvfr_pkg::rvfr_mode_t mode,
	input  logic [ADDR_WIDTH-1:0] exec_start,
	input  logic [ADDR_WIDTH-1:0] exec_end,
	output rvfr_pkg::rvfr_out_t  result
);
	import rvfr_pkg::*;

	logic [31:0] w;
	logic [6:0]  opc;
	logic [4:0]  rd, rs1, rs2;
	logic [2:0]  f3;
	logic [12:0] b_raw;
	logic [20:0] j_raw;
	logic [11:0] i_raw, s_raw;
	logic [15:0] i_imm16, s_imm16, b_imm16;
	logic [ADDR_WIDTH-1:0] pc_a, off_ext, dest;
	logic [63:0] dest64;
	logic        align_ok, in_exec, hi_ok;
	logic [31:0] zw, bw, sw0, swi, jw, cw;
	logic [4:0]  c_rd;
	logic [5:0]  c_imm6;

	always_comb begin
		w   = item.instr_word;
		opc = w[6:0];
		rd  = w[11:7];
		f3  = w[14:12];
		rs1 = w[19:15];
		rs2 = w[24:20];

		i_raw   = w[31:20];
		s_raw   = {w[31:25], w[11:7]};
		b_raw   = {w[31], w[7], w[30:25], w[11:8], 1'b0};
		j_raw   = {w[31], w[19:12], w[20], w[30:21], 1'b0};
		i_imm16 = {{4{i_raw[11]}}, i_raw};
		s_imm16 = {{4{s_raw[11]}}, s_raw};
		b_imm16 = {{3{b_raw[12]}}, b_raw} - 16'd4;

		// one target adder shared by branch and jal
		pc_a    = item.pc[ADDR_WIDTH-1:0];
		off_ext = (opc == OPC_JAL) ? {{(ADDR_WIDTH-21){j_raw[20]}}, j_raw}
		                           : {{(ADDR_WIDTH-13){b_raw[12]}}, b_raw};
		dest    = pc_a + off_ext - ADDR_WIDTH'(4);
		dest64  = 64'(dest);

		align_ok = mode.compressed_mode ? !dest[0] : (dest[1:0] == 2'b00);
		in_exec  = (dest >= exec_start) && (dest < exec_end);
		hi_ok    = mode.compressed_mode ? (dest64[63:JAL_LIMIT_BASE+1] == '0)
		                                : (dest64[63:JAL_LIMIT_BASE+2] == '0);

		zw  = {b_imm16, 8'd0, 3'd0, rs1};
		bw  = {b_imm16, 3'd0, rs1, 3'd0, rs2};
		sw0 = {s_imm16, 3'd0, rs1, 8'd0};
		swi = {s_imm16, 3'd0, rs1, 3'd0, rs2};
		jw  = mode.compressed_mode ? dest64[32:1] : dest64[33:2];

		c_rd   = w[11:7];
		c_imm6 = {w[12], w[6:2]};
		cw     = {w[31:16], {2{c_imm6[5]}}, c_imm6, 3'd0, c_rd};

		result.handler_code = HC_NONE;
		result.fast_word    = w;

		if (w[1:0] == 2'b11) begin
			case (opc)
				OPC_OP: begin
					if (rd != 5'd0 && f3 == 3'd0 && w[31:25] == 7'd0) begin
						result.handler_code = HC_ADD;
						result.fast_word    = {8'd0, 3'd0, rs2, 3'd0, rs1, 3'd0, rd};
					end
				end
				OPC_OP_IMM: begin
					if (rd != 5'd0 && f3 == 3'd0) begin
						if (rs1 == 5'd0) begin
							result.handler_code = HC_LI;
							result.fast_word    = {i_imm16, 8'd0, 3'd0, rd};
						end else if (i_raw == 12'd0) begin
							result.handler_code = HC_MV;
							result.fast_word    = {11'd0, rd, 11'd0, rs1};
						end else begin
							result.handler_code = HC_ADDI;
							result.fast_word    = {i_imm16, 3'd0, rd, 3'd0, rs1};
						end
					end
				end
				OPC_BRANCH: begin
					if (align_ok && (!mode.inbound_only || in_exec)) begin
						if (rs2 == 5'd0 && f3 == F3_B_EQ) begin
							result.handler_code = HC_BEQZ;
							result.fast_word    = zw;
						end else if (rs2 == 5'd0 && f3 == F3_B_NE) begin
							result.handler_code = HC_BNEZ;
							result.fast_word    = zw;
						end else if (rs2 == 5'd0 && f3 == F3_B_LT) begin
							result.handler_code = HC_BLTZ;
							result.fast_word    = zw;
						end else if (rs2 == 5'd0 && f3 == F3_B_GE) begin
							result.handler_code = HC_BGEZ;
							result.fast_word    = zw;
						end else begin
							case (f3)
								F3_B_EQ: begin
									result.handler_code = HC_BEQ;
									result.fast_word    = bw;
								end
								F3_B_NE: begin
									result.handler_code = HC_BNE;
									result.fast_word    = bw;
								end
								F3_B_LT: begin
									result.handler_code = HC_BLT;
									result.fast_word    = bw;
								end
								F3_B_GE: begin
									result.handler_code = HC_BGE;
									result.fast_word    = bw;
								end
								F3_B_LTU: begin
									result.handler_code = HC_BLTU;
									result.fast_word    = bw;
								end
								F3_B_GEU: begin
									result.handler_code = HC_BGEU;
									result.fast_word    = bw;
								end
								default: begin
									result.handler_code = HC_NONE;
								end
							endcase
						end
					end
				end
				OPC_STORE: begin
					if (rs2 == 5'd0) begin
						case (f3)
							F3_S_B: begin
								result.handler_code = HC_SB_ZERO;
								result.fast_word    = sw0;
							end
							F3_S_H: begin
								result.handler_code = HC_SH_ZERO;
								result.fast_word    = sw0;
							end
							F3_S_W: begin
								result.handler_code = HC_SW_ZERO;
								result.fast_word    = sw0;
							end
							F3_S_D: begin
								if (mode.wide_xlen) begin
									result.handler_code = HC_SD_ZERO;
									result.fast_word    = sw0;
								end
							end
							default: begin
								result.handler_code = HC_NONE;
							end
						endcase
					end else if (s_raw != 12'd0) begin
						if (f3 == F3_S_W) begin
							result.handler_code = HC_SW_IMM;
							result.fast_word    = swi;
						end else if (f3 == F3_S_D && mode.wide_xlen) begin
							result.handler_code = HC_SD_IMM;
							result.fast_word    = swi;
						end
					end
				end
				OPC_JAL: begin
					if (align_ok && hi_ok && in_exec) begin
						if (rd == 5'd0) begin
							result.handler_code = HC_JAL_X0;
							result.fast_word    = jw;
						end else if (rd == REG_RA) begin
							result.handler_code = HC_JAL_RA;
							result.fast_word    = jw;
						end
					end
				end
				default: begin
					result.handler_code = HC_NONE;
				end
			endcase
		end else if (c_rd != 5'd0) begin
			if ((w[15:0] & CI_OP_MASK) == CI_ADDI_CODE) begin
				result.handler_code = HC_C_ADDI;
				result.fast_word    = cw;
			end else if ((w[15:0] & CI_OP_MASK) == CI_LI_CODE) begin
				result.handler_code = HC_C_LI;
				result.fast_word    = cw;
			end
		end
	end

endmodule

`default_nettype wire

[tb/sv/riscv_fast_form_rewriter_check.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// riscv_fast_form_rewriter_check - fast-form result checker
// Watches the config, input and output channels, predicts the handler code
// and compact word of every fetched word and compares them in order.
// ----------------------------------------------------------------------------
module riscv_fast_form_rewriter_check #(
	parameter int ADDR_WIDTH = rvfr_pkg::DEFAULT_ADDR_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  rvfr_pkg::rvfr_in_t  in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  rvfr_pkg::rvfr_out_t out_data,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [63:0]         cfg_data,
	output int                  errors,
	output int                  outstanding
);
	import rvfr_pkg::*;

	localparam logic [2:0] F3_ADD = 3'd0;

	typedef struct packed {
		rvfr_in_t  src;
		rvfr_out_t form;
	} fetched_form_t;

	// shadow copy of the block's registers
	logic        cmode;
	logic        wide;
	logic        inbound;
	logic [63:0] lo_bound;
	logic [63:0] hi_bound;

	fetched_form_t expected_forms[$];

	function automatic bit in_exec(input logic [63:0] a, input logic [63:0] m);
		return a >= (lo_bound & m) && a < (hi_bound & m);
	endfunction

	function automatic rvfr_out_t rewrite_form(input rvfr_in_t item);
		logic [31:0] w;
		logic [31:0] word;
		logic [63:0] amask;
		logic [63:0] pc;
		logic [63:0] misal;
		logic [63:0] off;
		logic [63:0] dest;
		logic [4:0]  rd;
		logic [4:0]  rs1;
		logic [4:0]  rs2;
		logic [2:0]  f3;
		logic [11:0] iraw;
		logic [11:0] sraw;
		logic [12:0] braw;
		logic [20:0] jraw;
		logic [15:0] imm16;
		logic [15:0] half;
		logic [5:0]  imm6;
		int unsigned shift;
		rvfr_code_t  code;
		w = item.instr_word;
		amask = (ADDR_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << ADDR_WIDTH) - 64'd1);
		pc = item.pc & amask;
		shift = cmode ? 1 : 2;
		misal = cmode ? 64'd1 : 64'd3;
		rd = w[11:7];
		f3 = w[14:12];
		rs1 = w[19:15];
		rs2 = w[24:20];
		code = HC_NONE;
		word = w;
		if (w[1:0] == 2'b11) begin
			case (w[6:0])
				OPC_OP: begin
					if (rd != 5'd0 && f3 == F3_ADD && w[31:25] == 7'd0) begin
						code = HC_ADD;
						word = {8'd0, 3'd0, rs2, 3'd0, rs1, 3'd0, rd};
					end
				end
				OPC_OP_IMM: begin
					iraw = w[31:20];
					imm16 = {{4{iraw[11]}}, iraw};
					if (rd != 5'd0 && f3 == F3_ADD) begin
						if (rs1 == 5'd0) begin
							code = HC_LI;
							word = {imm16, 8'd0, 3'd0, rd};
						end else if (iraw == 12'd0) begin
							code = HC_MV;
							word = {11'd0, rd, 11'd0, rs1};
						end else begin
							code = HC_ADDI;
							word = {imm16, 3'd0, rd, 3'd0, rs1};
						end
					end
				end
				OPC_BRANCH: begin
					braw = {w[31], w[7], w[30:25], w[11:8], 1'b0};
					off = {{51{braw[12]}}, braw} - 64'd4;
					dest = (pc + off) & amask;
					imm16 = off[15:0];
					if ((dest & misal) == 64'd0 && (!inbound || in_exec(dest, amask))) begin
						if (rs2 == 5'd0) begin
							case (f3)
								F3_B_EQ: code = HC_BEQZ;
								F3_B_NE: code = HC_BNEZ;
								F3_B_LT: code = HC_BLTZ;
								F3_B_GE: code = HC_BGEZ;
								default: code = HC_NONE;
							endcase
							word = {imm16, 11'd0, rs1};
						end
						if (code == HC_NONE) begin
							case (f3)
								F3_B_EQ:  code = HC_BEQ;
								F3_B_NE:  code = HC_BNE;
								F3_B_LT:  code = HC_BLT;
								F3_B_GE:  code = HC_BGE;
								F3_B_LTU: code = HC_BLTU;
								F3_B_GEU: code = HC_BGEU;
								default:  code = HC_NONE;
							endcase
							word = {imm16, 3'd0, rs1, 3'd0, rs2};
						end
					end
				end
				OPC_STORE: begin
					sraw = {w[31:25], w[11:7]};
					imm16 = {{4{sraw[11]}}, sraw};
					if (rs2 == 5'd0) begin
						case (f3)
							F3_S_B:  code = HC_SB_ZERO;
							F3_S_H:  code = HC_SH_ZERO;
							F3_S_W:  code = HC_SW_ZERO;
							F3_S_D:  code = wide ? HC_SD_ZERO : HC_NONE;
							default: code = HC_NONE;
						endcase
						word = {imm16, 3'd0, rs1, 8'd0};
					end else if (sraw != 12'd0) begin
						if (f3 == F3_S_W)
							code = HC_SW_IMM;
						else if (f3 == F3_S_D && wide)
							code = HC_SD_IMM;
						word = {imm16, 3'd0, rs1, 3'd0, rs2};
					end
				end
				OPC_JAL: begin
					jraw = {w[31], w[19:12], w[20], w[30:21], 1'b0};
					dest = (pc + {{43{jraw[20]}}, jraw} - 64'd4) & amask;
					if ((dest & misal) == 64'd0 &&
					    dest < (64'd1 << (JAL_LIMIT_BASE + shift)) &&
					    in_exec(dest, amask)) begin
						word = 32'(dest >> shift);
						if (rd == 5'd0)
							code = HC_JAL_X0;
						else if (rd == REG_RA)
							code = HC_JAL_RA;
					end
				end
				default: code = HC_NONE;
			endcase
		end else begin
			half = w[15:0];
			rd = half[11:7];
			imm6 = {half[12], half[6:2]};
			word = {w[31:16], {2{imm6[5]}}, imm6, 3'd0, rd};
			if (rd != 5'd0 && (half & CI_OP_MASK) == CI_ADDI_CODE)
				code = HC_C_ADDI;
			else if (rd != 5'd0 && (half & CI_OP_MASK) == CI_LI_CODE)
				code = HC_C_LI;
		end
		if (code == HC_NONE)
			word = w;
		return '{handler_code: code, fast_word: word};
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		fetched_form_t head;
		int bad;
		if (!arst_n) begin
			cmode <= 1'b1;
			wide <= 1'b0;
			inbound <= 1'b0;
			lo_bound <= 64'd0;
			hi_bound <= 64'd0;
			errors <= 0;
			outstanding <= 0;
			expected_forms.delete();
		end else begin
			bad = 0;
			if (out_valid && out_ready) begin
				if (expected_forms.size() == 0) begin
					$error("result with nothing pending: handler_code %0d fast_word %h",
					       out_data.handler_code, out_data.fast_word);
					bad++;
				end else begin
					head = expected_forms.pop_front();
					if (out_data.handler_code !== head.form.handler_code) begin
						$error("handler_code mismatch (word %h pc %h): expected %0d, actual %0d",
						       head.src.instr_word, head.src.pc,
						       head.form.handler_code, out_data.handler_code);
						bad++;
					end
					if (out_data.fast_word !== head.form.fast_word) begin
						$error("fast_word mismatch (word %h pc %h): expected %h, actual %h",
						       head.src.instr_word, head.src.pc,
						       head.form.fast_word, out_data.fast_word);
						bad++;
					end
				end
			end
			if (in_valid && in_ready)
				expected_forms.push_back('{src: in_data, form: rewrite_form(in_data)});
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_COMPRESSED_MODE: cmode <= cfg_data[0];
					CFG_WIDE_XLEN:       wide <= cfg_data[0];
					CFG_INBOUND_ONLY:    inbound <= cfg_data[0];
					CFG_EXEC_START:      lo_bound <= cfg_data;
					CFG_EXEC_END:        hi_bound <= cfg_data;
					default: ;
				endcase
			end
			errors <= errors + bad;
			outstanding <= expected_forms.size();
		end
	end

endmodule

[tb/sv/riscv_fast_form_rewriter_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// riscv_fast_form_rewriter_test - fast-form rewriter testbench
// Drives directed and random instruction words through the rewriter under
// a series of register settings, with random gaps on the input side and
// random back-pressure on the output side. The checker beside the block
// predicts every result; this module only makes stimulus and the verdict.
// ----------------------------------------------------------------------------
module riscv_fast_form_rewriter_test;
	import rvfr_pkg::*;

	// percent chance that a side idles: before each input word, at each output draw
	localparam int IDLE_PCT = 16;
	localparam int NUM_PHASES = 8;
	localparam int WORDS_PER_PHASE = 238;
	// run limit, far beyond a slow but correct run
	localparam int RUN_LIMIT_NS = 1_000_000;

	localparam logic [4:0] REG_ZERO = 5'd0;
	localparam logic [2:0] F3_ADD = 3'd0;
	// branch funct3 with no branch behind it
	localparam logic [2:0] F3_B_RSVD = 3'd2;
	// highest index the config port can carry
	localparam logic [2:0] CFG_IDX_TOP = 3'd7;

	typedef struct packed {
		logic        cm;
		logic        wide;
		logic        inb;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] base;
	} phase_cfg_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	rvfr_in_t    in_data;
	logic        out_valid;
	logic        out_ready = 1'b0;
	rvfr_out_t   out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;
	int          fail_count;
	int          outstanding;
	// high for one whole phase: no idling on either side
	logic        calm = 1'b0;

	phase_cfg_t  cfg;

	riscv_fast_form_rewriter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	riscv_fast_form_rewriter_check u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.errors      (fail_count),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// output back-pressure, a fresh draw each cycle
	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// --- instruction encoders ---

	function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
	                                      input logic [4:0] rs1, input logic [2:0] f3,
	                                      input logic [4:0] rd);
		return {f7, rs2, rs1, f3, rd, OPC_OP};
	endfunction

	function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
	                                      input logic [2:0] f3, input logic [4:0] rd);
		return {imm, rs1, f3, rd, OPC_OP_IMM};
	endfunction

	function automatic logic [31:0] enc_b(input logic [12:0] off, input logic [4:0] rs2,
	                                      input logic [4:0] rs1, input logic [2:0] f3);
		return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11], OPC_BRANCH};
	endfunction

	function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [4:0] rs2,
	                                      input logic [4:0] rs1, input logic [2:0] f3);
		return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
	endfunction

	function automatic logic [31:0] enc_j(input logic [20:0] off, input logic [4:0] rd);
		return {off[20], off[10:1], off[11], off[19:12], rd, OPC_JAL};
	endfunction

	// CI format: funct3 and quadrant come from the match code
	function automatic logic [15:0] enc_c(input logic [15:0] code, input logic [5:0] imm,
	                                      input logic [4:0] rd);
		return code | {3'd0, imm[5], rd, imm[4:0], 2'd0};
	endfunction

	// --- random stimulus ---

	function automatic logic [4:0] pick_reg();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 12)
			return REG_ZERO;
		if (p < 22)
			return REG_RA;
		return 5'($urandom_range(0, 31));
	endfunction

	// mostly well-formed words of the rewritten kinds, some noise
	function automatic logic [31:0] rand_word(input logic cm);
		int unsigned pick;
		int unsigned u;
		logic [31:0] w;
		logic [12:0] boff;
		logic [20:0] joff;
		logic [11:0] imm;
		logic [6:0]  f7;
		logic [2:0]  f3;
		pick = $urandom_range(0, 99);
		u = $urandom;
		imm = 12'($urandom);
		f3 = 3'($urandom);
		if (pick < 10) begin
			f7 = (u[2:0] == 3'd0) ? 7'($urandom) : 7'd0;
			w = enc_r(f7, pick_reg(), pick_reg(), (u[5:3] == 3'd0) ? f3 : F3_ADD, pick_reg());
		end else if (pick < 22) begin
			if (u[1:0] == 2'd0)
				imm = '0;
			w = enc_i(imm, pick_reg(), (u[4:2] == 3'd0) ? f3 : F3_ADD, pick_reg());
		end else if (pick < 42) begin
			boff = 13'($urandom);
			// keep most targets word aligned when compressed mode is off
			if (!cm && u[1:0] != 2'd0)
				boff[1] = 1'b0;
			w = enc_b(boff, u[2] ? REG_ZERO : pick_reg(), pick_reg(), f3);
		end else if (pick < 57) begin
			if (u[1:0] == 2'd0)
				imm = '0;
			w = enc_s(imm, u[2] ? REG_ZERO : pick_reg(), pick_reg(),
			          (u[6:3] == 4'd0) ? f3 : 3'($urandom_range(F3_S_B, F3_S_D)));
		end else if (pick < 72) begin
			joff = 21'($urandom);
			// short hops mostly, so the target stays near the exec range
			if (u[3:0] != 4'd0) begin
				joff &= 21'h00FFFC;
				if (u[4])
					joff = -joff;
			end
			if (cm && u[5])
				joff[1] = 1'b1;
			w = enc_j(joff, (u[8:6] == 3'd0) ? pick_reg() : (u[9] ? REG_ZERO : REG_RA));
		end else if (pick < 84) begin
			w = {16'($urandom), enc_c(u[0] ? CI_ADDI_CODE : CI_LI_CODE, 6'($urandom),
			                          pick_reg())};
		end else if (pick < 92) begin
			w = $urandom;
			if (w[1:0] == 2'b11)
				w[0] = 1'b0;
		end else begin
			w = $urandom;
		end
		return w;
	endfunction

	// pc near the phase base, with odd, wild and wrapping ones mixed in
	function automatic logic [63:0] rand_pc(input logic [63:0] base, input logic cm);
		int unsigned pick;
		logic [63:0] pc;
		pick = $urandom_range(0, 99);
		if (pick < 80) begin
			pc = base + ($urandom_range(0, 32'hFFFF) & (cm ? 32'hFFFE : 32'hFFFC));
			if (pick < 4)
				pc[0] = 1'b1;
			else if (pick < 8)
				pc[1] = 1'b1;
		end else if (pick < 90) begin
			pc = {$urandom, $urandom};
		end else if (pick < 95) begin
			pc = {48'hFFFF_FFFF_FFFF, 16'($urandom)};
		end else begin
			pc = {48'd0, 16'($urandom)};
		end
		return pc;
	endfunction

	function automatic logic [63:0] with_bit(input logic b);
		logic [63:0] v;
		v = {$urandom, $urandom};
		v[0] = b;
		return v;
	endfunction

	// register settings per phase; the last one is drawn at random
	function automatic phase_cfg_t phase_cfg(input int n);
		phase_cfg_t p;
		logic [63:0] lo;
		case (n)
			0: p = '{1'b0, 1'b1, 1'b1, 64'h1000, 64'h11000, 64'h1000};
			1: p = '{1'b1, 1'b1, 1'b0, 64'h1000, 64'h11000, 64'h1000};
			// around the JAL limit for each alignment
			2: p = '{1'b1, 1'b0, 1'b1, 64'h1_FFFF_8000, 64'h2_0000_8000, 64'h1_FFFF_8000};
			3: p = '{1'b0, 1'b1, 1'b1, 64'h3_FFFF_8000, 64'h4_0000_8000, 64'h3_FFFF_8000};
			// whole address space
			4: p = '{1'b0, 1'b0, 1'b1, 64'd0, {64{1'b1}}, 64'h3_FFFF_8000};
			// empty range: start above end
			5: p = '{1'b1, 1'b1, 1'b1, {64{1'b1}}, 64'd0, 64'h1000};
			// top of the address space, branches wrap
			6: p = '{1'b1, 1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_0000, {64{1'b1}},
			         64'hFFFF_FFFF_FFFF_0000};
			default: begin
				lo = {32'd0, $urandom};
				p = '{1'($urandom), 1'($urandom), 1'($urandom), lo,
				      lo + $urandom_range(0, 32'h20000), lo};
			end
		endcase
		return p;
	endfunction

	// --- channel drivers ---

	// one input transfer; valid holds until accepted
	task automatic send_word(input logic [31:0] w, input logic [63:0] pc);
		if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{instr_word: w, pc: pc};
		do @(posedge clk); while (!(in_valid && in_ready));
	endtask

	// caller lowers cfg_valid after its last write
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
	endtask

	// the count is registered and lags, so always step past the last transfer first
	task automatic drain();
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words at the reset settings: 2-byte alignment, narrow
		// stores only, branches unbounded, empty exec range
		send_word(enc_r(7'd0, 5'd31, 5'd31, F3_ADD, 5'd31), 64'h1000);
		send_word(enc_r(7'd0, 5'd3, 5'd2, F3_ADD, REG_ZERO), 64'h1000);
		send_word(enc_r(7'h20, 5'd3, 5'd2, F3_ADD, REG_RA), 64'h1000);
		send_word(enc_i(12'h800, REG_ZERO, F3_ADD, 5'd5), 64'h1000);
		send_word(enc_i(12'h000, 5'd9, F3_ADD, 5'd7), 64'h1000);
		send_word(enc_i(12'h7FF, 5'd2, F3_ADD, REG_RA), 64'h1000);
		send_word(enc_i(12'h005, 5'd2, F3_ADD, REG_ZERO), 64'h1000);
		send_word(enc_i(12'h001, 5'd2, 3'd1, 5'd3), 64'h1000);
		send_word(enc_b(13'h1000, REG_ZERO, 5'd4, F3_B_EQ), 64'h1000);
		send_word(enc_b(13'h0FFE, REG_ZERO, 5'd31, F3_B_GE), 64'h1000);
		// unsigned compares against x0 keep the two-register form
		send_word(enc_b(13'h0008, REG_ZERO, 5'd5, F3_B_LTU), 64'h1000);
		send_word(enc_b(13'h0008, 5'd3, 5'd5, F3_B_RSVD), 64'h1000);
		// misaligned target
		send_word(enc_b(13'h0008, 5'd3, 5'd5, F3_B_NE), 64'h1001);
		// backward branch from pc 0 wraps
		send_word(enc_b(13'h1FF0, 5'd6, 5'd7, F3_B_LT), 64'h0);
		send_word(enc_s(12'h800, REG_ZERO, 5'd31, F3_S_B), 64'h1000);
		send_word(enc_s(12'h000, REG_ZERO, 5'd2, F3_S_H), 64'h1000);
		// 64-bit store with narrow XLEN stays as is
		send_word(enc_s(12'h008, REG_ZERO, 5'd2, F3_S_D), 64'h1000);
		send_word(enc_s(12'h7FF, 5'd31, 5'd2, F3_S_W), 64'h1000);
		send_word(enc_s(12'h000, 5'd5, 5'd2, F3_S_W), 64'h1000);
		send_word(enc_j(21'h000100, REG_ZERO), 64'h1000);
		send_word({16'hFFFF, enc_c(CI_ADDI_CODE, 6'h20, 5'd31)}, 64'h1000);
		send_word({16'h0000, enc_c(CI_LI_CODE, 6'h1F, REG_RA)}, 64'h1000);
		send_word(32'hFFFF_FFFF, {64{1'b1}});
		send_word(32'h0000_0000, 64'h0);
		in_valid <= 1'b0;

		for (int n = 0; n < NUM_PHASES; n++) begin
			cfg = phase_cfg(n);
			calm <= (n == 1);
			// registers change only with nothing in flight
			drain();
			write_reg(CFG_COMPRESSED_MODE, with_bit(cfg.cm));
			write_reg(CFG_WIDE_XLEN, with_bit(cfg.wide));
			write_reg(CFG_INBOUND_ONLY, with_bit(cfg.inb));
			write_reg(CFG_EXEC_START, cfg.lo);
			write_reg(CFG_EXEC_END, cfg.hi);
			// a write to an index past the last register must be ignored
			write_reg(3'($urandom_range(CFG_EXEC_END + 1, CFG_IDX_TOP)),
			          {$urandom, $urandom});
			cfg_valid <= 1'b0;
			if (n == 0) begin
				// in range, word aligned: rewritten
				send_word(enc_j(21'h000104, REG_RA), 64'h2000);
				// rd other than x0 or ra
				send_word(enc_j(21'h000104, 5'd2), 64'h2000);
				// target just below the exec range
				send_word(enc_j(21'h1FFF00, REG_ZERO), 64'h1000);
				send_word(enc_s(12'h010, 5'd7, 5'd2, F3_S_D), 64'h1000);
				send_word(enc_s(12'hFF0, REG_ZERO, 5'd2, F3_S_D), 64'h1000);
			end
			repeat (WORDS_PER_PHASE) send_word(rand_word(cfg.cm), rand_pc(cfg.base, cfg.cm));
			in_valid <= 1'b0;
		end

		drain();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#RUN_LIMIT_NS;
		$display("FAIL");
		$finish;
	end

endmodule
